// ===== rtl/core/ptrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrfc_pkg: shared types, codes and tables of the planar tile row converter
// Holds the format and status codes, the row word passed from the front part
// to the back part, the control group from the register block and the
// character tables for pixel and hex text.
// ----------------------------------------------------------------------------
package ptrfc_pkg;

  // Format codes (input_format and output_format registers)
  localparam logic [1:0] FMT_PIXEL = 2'd0;
  localparam logic [1:0] FMT_HEX   = 2'd1;
  localparam logic [1:0] FMT_RAW   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_CHAR  = 2'd0;
  localparam logic [1:0] STAT_END   = 2'd1;
  localparam logic [1:0] STAT_EARLY = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_IN_FMT  = 2'd0;
  localparam logic [1:0] REG_OUT_FMT = 2'd1;
  localparam logic [1:0] REG_OFFSET  = 2'd2;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;

  // Row word between front and back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Longest output burst of one row: eight pixels and two newlines
  localparam int            MAX_CHARS = 10;
  localparam int            CIDX_W    = $clog2(MAX_CHARS);
  localparam logic [CIDX_W-1:0] PIX_NL_IDX  = CIDX_W'(8);
  localparam logic [CIDX_W-1:0] PIX_NL2_IDX = CIDX_W'(9);

  typedef struct packed {
    logic       is_end;    // end of stream marker
    logic       early;     // end came mid-row
    logic [7:0] lo;        // low bit plane
    logic [7:0] hi;        // high bit plane
  } job_t;

  typedef struct packed {
    logic [1:0] in_fmt;
    logic [1:0] out_fmt;
    logic [3:0] line_offset;
    logic       clr_row;   // input_format written: drop partial row
    logic       reload_lc; // line_offset written: reload line counter
    logic [3:0] load_val;  // value written with reload_lc
  } cfg_ctrl_t;

  // Hex digit decode table: ((c | 4400) mod 55), built at elaboration
  typedef logic [255:0][5:0] hex_lut_t;

  function automatic hex_lut_t build_hex_lut();
    hex_lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 6'((i | 4400) % 55);
    end
    return t;
  endfunction

  localparam hex_lut_t HEX_LUT = build_hex_lut();

  function automatic logic is_skip(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) ||
           (c == CH_CR) || (c == CH_DASH);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + {4'b0, n};
    else return CH_A + {4'b0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] pix_char(logic [1:0] v);
    logic [7:0] ch;
    case (v)
      2'd0:    ch = CH_DOT;
      2'd1:    ch = CH_PLUS;
      2'd2:    ch = CH_STAR;
      default: ch = CH_HASH;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/ptrfc_front.sv =====
// ----------------------------------------------------------------------------
// ptrfc_front: input word parsing and row assembly
// Decodes pixel, hex or raw input words into the two bit planes of a row and
// pushes each finished row, or an end marker, into the row queue.
// ----------------------------------------------------------------------------
module ptrfc_front
  import ptrfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_ctrl_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_char,
  input  logic      in_end,
  input  logic      q_full,
  output logic      q_push,
  output job_t      q_job
);

  logic [2:0] idx_r, idx_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [3:0] held_r, held_nxt;

  logic       accept;
  logic       skip;
  logic [1:0] pix_v;
  logic [5:0] digit;
  logic [7:0] hex_byte;
  logic       done;
  logic [7:0] row_lo, row_hi;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign skip     = is_skip(in_char);
  assign digit    = HEX_LUT[in_char];
  assign hex_byte = {held_r, 4'b0000} | {2'b00, digit};

  // Classify the pixel character
  always_comb begin
    if (in_char == CH_DOT)       pix_v = 2'd0;
    else if (in_char == CH_PLUS) pix_v = 2'd1;
    else if (in_char == CH_STAR) pix_v = 2'd2;
    else                         pix_v = 2'd3;
  end

  // Advance the row under assembly
  always_comb begin
    idx_nxt  = idx_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    held_nxt = held_r;
    done     = 1'b0;
    row_lo   = lo_r;
    row_hi   = hi_r;
    if (accept && !in_end) begin
      unique case (cfg.in_fmt)
        FMT_PIXEL: begin
          if (!skip) begin
            lo_nxt  = {lo_r[6:0], pix_v[0]};
            hi_nxt  = {hi_r[6:0], pix_v[1]};
            idx_nxt = idx_r + 3'd1;
            row_lo  = lo_nxt;
            row_hi  = hi_nxt;
            done    = (idx_r == 3'd7);
          end
        end
        FMT_HEX: begin
          if (!skip) begin
            case (idx_r[1:0])
              2'd0: begin
                held_nxt = digit[3:0];
                idx_nxt  = 3'd1;
              end
              2'd1: begin
                lo_nxt  = hex_byte;
                idx_nxt = 3'd2;
              end
              2'd2: begin
                held_nxt = digit[3:0];
                idx_nxt  = 3'd3;
              end
              default: begin
                row_hi = hex_byte;
                done   = 1'b1;
              end
            endcase
          end
        end
        FMT_RAW: begin
          if (idx_r == 3'd0) begin
            lo_nxt  = in_char;
            idx_nxt = 3'd1;
          end else begin
            row_hi = in_char;
            done   = 1'b1;
          end
        end
        default: begin
          // unknown input format: ignore the word
        end
      endcase
    end
    // Drop the row state once a row completes, at end of stream or on reformat
    if (done || (accept && in_end) || cfg.clr_row) begin
      idx_nxt  = 3'd0;
      lo_nxt   = 8'h00;
      hi_nxt   = 8'h00;
      held_nxt = 4'h0;
    end
  end

  // Push finished rows (unless output is off) and end markers
  always_comb begin
    q_job.is_end = accept && in_end;
    q_job.early  = (idx_r != 3'd0);
    q_job.lo     = row_lo;
    q_job.hi     = row_hi;
    q_push       = (accept && in_end) ||
                   (done && (cfg.out_fmt == FMT_PIXEL || cfg.out_fmt == FMT_HEX ||
                             cfg.out_fmt == FMT_RAW));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 3'd0;
      lo_r   <= 8'h00;
      hi_r   <= 8'h00;
      held_r <= 4'h0;
    end else begin
      idx_r  <= idx_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== rtl/core/ptrfc_queue.sv =====
// ----------------------------------------------------------------------------
// ptrfc_queue: short row queue between front and back
// Holds finished rows and end markers so the parser keeps taking words while
// the emitter works through a burst of output characters.
// ----------------------------------------------------------------------------
module ptrfc_queue
  import ptrfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/ptrfc_back.sv =====
// ----------------------------------------------------------------------------
// ptrfc_back: row emitter
// Expands the head row of the queue into output characters, one per cycle
// unless stalled, into a registered output; keeps the 4-bit line counter.
// ----------------------------------------------------------------------------
module ptrfc_back
  import ptrfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_ctrl_t  cfg,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic [CIDX_W-1:0] cidx_r, cidx_nxt;
  logic [3:0]        lc_r, lc_nxt;
  logic              ov_r, ov_nxt;
  logic [7:0]        och_r, och_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic              olast_r, olast_nxt;

  logic       advance;
  logic [3:0] lc_plus;
  logic       emit;
  logic       final_ch;
  logic [7:0] ch;
  logic [1:0] st;
  logic [2:0] bit_sel;

  assign advance = head_valid && (!ov_r || out_ready);
  assign lc_plus = lc_r + 4'd2;
  assign bit_sel = ~cidx_r[2:0];
  assign pop     = advance && final_ch;

  // Pick the character for the current step of the row
  always_comb begin
    emit     = 1'b1;
    final_ch = 1'b0;
    ch       = 8'h00;
    st       = STAT_CHAR;
    if (head_job.is_end) begin
      st       = head_job.early ? STAT_EARLY : STAT_END;
      final_ch = 1'b1;
    end else begin
      unique case (cfg.out_fmt)
        FMT_PIXEL: begin
          if (cidx_r == PIX_NL_IDX) begin
            ch       = CH_NL;
            final_ch = (lc_plus != 4'd0);
          end else if (cidx_r == PIX_NL2_IDX) begin
            ch       = CH_NL;
            final_ch = 1'b1;
          end else begin
            ch = pix_char({head_job.hi[bit_sel], head_job.lo[bit_sel]});
          end
        end
        FMT_HEX: begin
          case (cidx_r)
            CIDX_W'(0): ch = hex_char(head_job.lo[7:4]);
            CIDX_W'(1): ch = hex_char(head_job.lo[3:0]);
            CIDX_W'(2): ch = CH_SPACE;
            CIDX_W'(3): ch = hex_char(head_job.hi[7:4]);
            CIDX_W'(4): ch = hex_char(head_job.hi[3:0]);
            default: begin
              ch       = (lc_plus == 4'd0) ? CH_NL : CH_SPACE;
              final_ch = 1'b1;
            end
          endcase
        end
        FMT_RAW: begin
          if (cidx_r == '0) begin
            ch = head_job.lo;
          end else begin
            ch       = head_job.hi;
            final_ch = 1'b1;
          end
        end
        default: begin
          // output switched off: retire the row silently
          emit     = 1'b0;
          final_ch = 1'b1;
        end
      endcase
    end
  end

  // Step through the row and update the line counter at its end
  always_comb begin
    cidx_nxt = cidx_r;
    lc_nxt   = lc_r;
    if (advance) begin
      if (final_ch) begin
        cidx_nxt = '0;
        if (head_job.is_end) begin
          lc_nxt = cfg.line_offset;
        end else if (cfg.out_fmt == FMT_PIXEL || cfg.out_fmt == FMT_HEX) begin
          lc_nxt = lc_plus;
        end
      end else begin
        cidx_nxt = cidx_r + 1'b1;
      end
    end
    if (cfg.reload_lc) begin
      lc_nxt = cfg.load_val;
    end
  end

  // Load the output register; hold it while the sink stalls
  always_comb begin
    ov_nxt    = ov_r;
    och_nxt   = och_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;
    if (!ov_r || out_ready) begin
      ov_nxt    = advance && emit;
      och_nxt   = ch;
      ost_nxt   = st;
      olast_nxt = final_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cidx_r <= '0;
      lc_r   <= 4'd0;
      ov_r   <= 1'b0;
    end else begin
      cidx_r <= cidx_nxt;
      lc_r   <= lc_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    och_r   <= och_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid  = ov_r;
  assign out_char   = och_r;
  assign out_status = ost_r;
  assign out_last   = olast_r;

endmodule

// ===== rtl/core/planar_tile_row_format_converter.sv =====
// ----------------------------------------------------------------------------
// planar_tile_row_format_converter: 2bpp planar tile row format converter
// Parses a byte stream of pixel characters, hex text or raw bytes into tile
// rows and writes each row back out as pixel characters, hex text or bytes.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_      sink       tdata[7:0] in_char, tlast end_of_input
//  out_     source     tdata[7:0] out_char, tuser[1:0] status, tlast last
//  cfg_     APB slave  0x0 input_format, 0x4 output_format, 0x8 line_offset
//
//  An input word is taken every cycle while the two-entry row queue has room.
//  The emitter sends one character per cycle unless out_tready stalls it:
//  rows are 2 (raw), 6 (hex) or 9 to 10 (pixel) chars, end markers one word.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A stalled output holds its register; the queue then fills and in_tready
//  drops until the emitter retires a row.
// ----------------------------------------------------------------------------
module planar_tile_row_format_converter
  import ptrfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,  // last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [1:0] in_fmt_r, in_fmt_nxt;
  logic [1:0] out_fmt_r, out_fmt_nxt;
  logic [3:0] offset_r, offset_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;
  cfg_ctrl_t  cfg;

  logic q_push, q_full, q_pop, q_head_valid;
  job_t q_in_job, q_head_job;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  // Decode register writes
  always_comb begin
    in_fmt_nxt    = in_fmt_r;
    out_fmt_nxt   = out_fmt_r;
    offset_nxt    = offset_r;
    cfg.clr_row   = 1'b0;
    cfg.reload_lc = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IN_FMT: begin
          in_fmt_nxt  = cfg_pwdata[1:0];
          cfg.clr_row = 1'b1;
        end
        REG_OUT_FMT: out_fmt_nxt = cfg_pwdata[1:0];
        REG_OFFSET: begin
          offset_nxt    = cfg_pwdata[3:0];
          cfg.reload_lc = 1'b1;
        end
        default: begin
          // no register here
        end
      endcase
    end
    cfg.in_fmt      = in_fmt_r;
    cfg.out_fmt     = out_fmt_r;
    cfg.line_offset = offset_r;
    cfg.load_val    = cfg_pwdata[3:0];
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_IN_FMT:  cfg_prdata = {30'd0, in_fmt_r};
      REG_OUT_FMT: cfg_prdata = {30'd0, out_fmt_r};
      REG_OFFSET:  cfg_prdata = {28'd0, offset_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_fmt_r  <= FMT_PIXEL;
      out_fmt_r <= FMT_PIXEL;
      offset_r  <= 4'd0;
    end else begin
      in_fmt_r  <= in_fmt_nxt;
      out_fmt_r <= out_fmt_nxt;
      offset_r  <= offset_nxt;
    end
  end

  ptrfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_char  (in_tdata),
    .in_end   (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in_job)
  );

  ptrfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  ptrfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

// ===== rtl/core/ptrfc_checker.sv =====
// ----------------------------------------------------------------------------
// ptrfc_checker: port-level checks of the planar tile row converter
// Watches the result stream and the configuration port of the top level.
// ----------------------------------------------------------------------------
module ptrfc_checker
  import ptrfc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast,
  input logic       cfg_pready
);

  // A stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result word changed");

  // End reports are single words with no character
  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_END || out_tuser == STAT_EARLY) |->
    out_tlast && (out_tdata == 8'h00))
    else $error("end report not a lone empty word");

  // Status code stays within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STAT_CHAR || out_tuser == STAT_END ||
                    out_tuser == STAT_EARLY))
    else $error("undefined status code");

  // The register port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

  // No result word is valid just after a reset cycle
  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word without a source");

endmodule

bind planar_tile_row_format_converter ptrfc_checker u_ptrfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);
